// ===== src/ehc_pkg.sv =====
`timescale 1ns / 1ps

package ehc_pkg;

  // frame header window and length counter
  localparam int HDR_DEPTH     = 22;
  localparam int LEN_WIDTH_DEF = 16;

  // ethernet header layout
  localparam int BASE_HDR_LEN = 14;
  localparam int VLAN_HDR_LEN = 18;
  localparam int QINQ_HDR_LEN = 22;
  localparam int DST_MAC_LEN  = 6;
  localparam int SRC_MAC_LEN  = 12;
  localparam int TAG_WORD_LEN = 16;

  localparam logic [15:0] TPID_VLAN     = 16'h8100;
  localparam logic [15:0] TPID_QINQ_OLD = 16'h9100;
  localparam logic [15:0] ETYPE_NONE    = 16'hFFFF;

  localparam logic [4:0] OFF_NONE = 5'd0;
  localparam logic [4:0] OFF_BASE = 5'd14;
  localparam logic [4:0] OFF_VLAN = 5'd18;
  localparam logic [4:0] OFF_QINQ = 5'd22;

  // configuration register map, 8-byte stride
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_DST_MAC  = 2'd0,
    REG_SRC_MAC  = 2'd1,
    REG_TAG_WORD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] tag_word;
  } cfg_regs_t;

  typedef logic [HDR_DEPTH-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [4:0]  payload_offset;
    logic [15:0] payload_length;
    logic        dst_match;
    logic        src_match;
    logic        tag_match;
  } out_item_t;

endpackage

// ===== src/ehc_cfg.sv =====
`timescale 1ns / 1ps

module ehc_cfg import ehc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_regs_t             cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  cfg_idx_t  reg_idx;
  logic      wr_en;

  assign reg_idx = cfg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    unique case (reg_idx)
      REG_DST_MAC: begin
        prdata = {16'h0, cfg_r.dst_mac};
        if (wr_en) cfg_nxt.dst_mac = pwdata[47:0];
      end
      REG_SRC_MAC: begin
        prdata = {16'h0, cfg_r.src_mac};
        if (wr_en) cfg_nxt.src_mac = pwdata[47:0];
      end
      REG_TAG_WORD: begin
        prdata = {32'h0, cfg_r.tag_word};
        if (wr_en) cfg_nxt.tag_word = pwdata[31:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/ehc_capture.sv =====
`timescale 1ns / 1ps

module ehc_capture import ehc_pkg::*; #(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 take,
  output logic                 frame_done,
  output logic [LEN_WIDTH-1:0] frame_len,
  output hdr_t                 hdr
);

  localparam logic [LEN_WIDTH-1:0] CNT_MAX = {LEN_WIDTH{1'b1}};

  logic [LEN_WIDTH-1:0] count_r, count_nxt;
  logic [LEN_WIDTH-1:0] len_r, len_nxt;
  logic                 done_r, done_nxt;
  logic [LEN_WIDTH-1:0] count_inc;
  logic                 accept;
  hdr_t                 hdr_r;

  // a finished frame holds the header until the result register takes it
  assign in_stall   = done_r && !take;
  assign accept     = in_valid && !in_stall;
  assign count_inc  = (count_r == CNT_MAX) ? count_r : count_r + 1'b1;
  assign frame_done = done_r;
  assign frame_len  = len_r;
  assign hdr        = hdr_r;

  always_comb begin
    count_nxt = count_r;
    len_nxt   = len_r;
    done_nxt  = done_r && !take;
    if (accept) begin
      if (in_data.last) begin
        count_nxt = '0;
        len_nxt   = count_inc;
        done_nxt  = 1'b1;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    for (int i = 0; i < HDR_DEPTH; i++) begin
      if (accept && count_r == LEN_WIDTH'(i)) hdr_r[i] <= in_data.data_byte;
    end
  end

  a_stall_only_when_holding: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> done_r)
    else $error("input stalled with no finished frame waiting");

endmodule

// ===== src/ehc_classify.sv =====
`timescale 1ns / 1ps

module ehc_classify import ehc_pkg::*; #(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 frame_done,
  input  logic [LEN_WIDTH-1:0] frame_len,
  input  hdr_t                 hdr,
  input  cfg_regs_t            cfg,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r;
  out_item_t            res;
  logic [15:0]          outer;
  logic                 is_qinq, is_vlan;
  logic                 ge_base, ge_vlan, ge_qinq, gt_base, gt_vlan, gt_qinq;
  logic [LEN_WIDTH-1:0] plen;

  assign take      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign outer   = {hdr[12], hdr[13]};
  assign is_qinq = (outer == TPID_QINQ_OLD);
  assign is_vlan = (outer == TPID_VLAN);
  assign ge_base = frame_len >= LEN_WIDTH'(BASE_HDR_LEN);
  assign ge_vlan = frame_len >= LEN_WIDTH'(VLAN_HDR_LEN);
  assign ge_qinq = frame_len >= LEN_WIDTH'(QINQ_HDR_LEN);
  assign gt_base = frame_len >  LEN_WIDTH'(BASE_HDR_LEN);
  assign gt_vlan = frame_len >  LEN_WIDTH'(VLAN_HDR_LEN);
  assign gt_qinq = frame_len >  LEN_WIDTH'(QINQ_HDR_LEN);

  always_comb begin
    res = '0;

    if (!ge_base) res.ether_type = ETYPE_NONE;
    else if (is_qinq && ge_qinq) res.ether_type = {hdr[20], hdr[21]};
    else if (is_vlan && ge_vlan) res.ether_type = {hdr[16], hdr[17]};
    else res.ether_type = outer;

    // a tag is stripped from the payload only when payload remains past it
    if (!gt_base) res.payload_offset = OFF_NONE;
    else if (is_qinq && gt_qinq) res.payload_offset = OFF_QINQ;
    else if (is_vlan && gt_vlan) res.payload_offset = OFF_VLAN;
    else res.payload_offset = OFF_BASE;

    plen = frame_len - LEN_WIDTH'(res.payload_offset);
    res.payload_length = gt_base ? 16'(plen) : 16'h0;

    res.dst_match = (frame_len >= LEN_WIDTH'(DST_MAC_LEN)) &&
                    ({hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]} == cfg.dst_mac);
    res.src_match = (frame_len >= LEN_WIDTH'(SRC_MAC_LEN)) &&
                    ({hdr[6], hdr[7], hdr[8], hdr[9], hdr[10], hdr[11]} == cfg.src_mac);
    res.tag_match = (frame_len >= LEN_WIDTH'(TAG_WORD_LEN)) &&
                    ({hdr[12], hdr[13], hdr[14], hdr[15]} == cfg.tag_word);
  end

  assign out_valid_nxt = take ? frame_done : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= res;
  end

  a_done_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done && take |=> out_valid_r)
    else $error("finished frame did not reach the result register");

  a_offset_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.payload_offset == OFF_NONE ||
                     out_data_r.payload_offset == OFF_BASE ||
                     out_data_r.payload_offset == OFF_VLAN ||
                     out_data_r.payload_offset == OFF_QINQ))
    else $error("payload offset outside the header layouts");

  a_offset_length_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.payload_offset == OFF_NONE) ==
                     (out_data_r.payload_length == 16'h0)))
    else $error("payload offset and length disagree on payload presence");

endmodule

// ===== src/ethernet_header_classifier.sv =====
// result path: after the transfer of a frame's last byte its result passes the header
// capture register, then the result register, and waits while out_stall holds
// throughput: one byte per cycle, frames back to back; the input stalls only when a
// finished frame and an unread result are both waiting and out_stall is high
// reset: synchronous rst_n clears the byte count, valid flags and configuration registers;
// the 22-byte header store is not reset, bytes past the frame length are never used
`timescale 1ns / 1ps

module ethernet_header_classifier import ehc_pkg::*; #(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  // byte stream in
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,

  // one result per frame out
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,

  // register port: dst_mac at 0x00, src_mac at 0x08, tag_word at 0x10
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_regs_t            cfg;
  logic                 take;
  logic                 frame_done;
  logic [LEN_WIDTH-1:0] frame_len;
  hdr_t                 hdr;

  // configuration registers; the user must write them only between frames, the block does not enforce it
  ehc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte count, header window capture, frame length at the last byte
  ehc_capture #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .frame_done (frame_done),
    .frame_len  (frame_len),
    .hdr        (hdr)
  );

  // tag decode, payload offset/length and address matches into the result register;
  // the capture stage keeps its finished frame until this register takes it
  ehc_classify #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_done (frame_done),
    .frame_len  (frame_len),
    .hdr        (hdr),
    .cfg        (cfg),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== sim/ethernet_header_classifier_tb.sv =====
`timescale 1ns / 1ps

module ethernet_header_classifier_tb;
  import ehc_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  // header capture then result register
  localparam int RESULT_LATENCY = 2;
  // address slot past the last register, writes there must be dropped
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // byte stream side
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;

  // result side
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // register port
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  ethernet_header_classifier #(
    .LEN_WIDTH(LEN_WIDTH_DEF)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // bytes waiting to be offered to the block
  in_item_t byte_queue[$];
  // one summary per closed frame, oldest first
  out_item_t frame_results[$];

  // our own copy of the classifier state and its registers
  logic [47:0] dst_mac_cfg = '0;
  logic [47:0] src_mac_cfg = '0;
  logic [31:0] tag_word_cfg = '0;
  logic [LEN_WIDTH_DEF-1:0] frame_len_seen = '0;
  logic [7:0] header_copy [HDR_DEPTH];

  int fail_count = 0;
  int cycle_count = 0;
  int in_gap = 0;
  int out_gap = 0;
  // no idling on either side once set
  bit tail_quiet = 1'b0;
  out_item_t next_result;

  initial begin
    for (int i = 0; i < HDR_DEPTH; i++) header_copy[i] = 8'h00;
  end

  // per-byte capture and count; on the last byte, build the frame summary
  function automatic void track_frame_byte(in_item_t item);
    logic [LEN_WIDTH_DEF-1:0] len;
    logic [LEN_WIDTH_DEF-1:0] remain;
    logic [15:0] outer;
    out_item_t res;
    if (frame_len_seen < HDR_DEPTH) header_copy[frame_len_seen] = item.data_byte;
    if (frame_len_seen != '1) frame_len_seen++;
    if (!item.last) return;

    len = frame_len_seen;
    frame_len_seen = '0;

    // inner ethertype, looking through a vlan or old qinq tag when the frame holds it
    outer = 16'h0000;
    res.ether_type = ETYPE_NONE;
    if (len >= BASE_HDR_LEN) begin
      outer = {header_copy[12], header_copy[13]};
      res.ether_type = outer;
      if (outer == TPID_QINQ_OLD && len >= QINQ_HDR_LEN)
        res.ether_type = {header_copy[20], header_copy[21]};
      else if (outer == TPID_VLAN && len >= VLAN_HDR_LEN)
        res.ether_type = {header_copy[16], header_copy[17]};
    end

    // payload window; a tag is only stripped when payload is left behind it
    res.payload_offset = OFF_NONE;
    res.payload_length = '0;
    if (len > BASE_HDR_LEN) begin
      remain = len - BASE_HDR_LEN;
      if (remain > 8 && outer == TPID_QINQ_OLD) remain = remain - 8;
      else if (remain > 4 && outer == TPID_VLAN) remain = remain - 4;
      res.payload_length = remain;
      res.payload_offset = 5'(len - remain);
    end

    res.dst_match = (len >= DST_MAC_LEN) &&
        ({header_copy[0], header_copy[1], header_copy[2],
          header_copy[3], header_copy[4], header_copy[5]} == dst_mac_cfg);
    res.src_match = (len >= SRC_MAC_LEN) &&
        ({header_copy[6], header_copy[7], header_copy[8],
          header_copy[9], header_copy[10], header_copy[11]} == src_mac_cfg);
    res.tag_match = (len >= TAG_WORD_LEN) &&
        ({header_copy[12], header_copy[13], header_copy[14], header_copy[15]} == tag_word_cfg);
    frame_results.push_back(res);
  endfunction

  // input driver: valid holds with its payload until the transfer happens
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) track_frame_byte(in_data);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (!tail_quiet && $urandom_range(0, 11) == 0) begin
          // idle burst: valid drops and a random gap count is loaded
          in_valid <= 1'b0;
          in_gap <= $urandom_range(0, 15);
        end else if (byte_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_results.size() == 0) begin
          $error("result transfer with no frame outstanding: %p", out_data);
          fail_count++;
        end else begin
          next_result = frame_results.pop_front();
          if (out_data.ether_type !== next_result.ether_type) begin
            $error("ether_type: expected %h, got %h", next_result.ether_type, out_data.ether_type);
            fail_count++;
          end
          if (out_data.payload_offset !== next_result.payload_offset) begin
            $error("payload_offset: expected %0d, got %0d",
                   next_result.payload_offset, out_data.payload_offset);
            fail_count++;
          end
          if (out_data.payload_length !== next_result.payload_length) begin
            $error("payload_length: expected %0d, got %0d",
                   next_result.payload_length, out_data.payload_length);
            fail_count++;
          end
          if (out_data.dst_match !== next_result.dst_match) begin
            $error("dst_match: expected %b, got %b", next_result.dst_match, out_data.dst_match);
            fail_count++;
          end
          if (out_data.src_match !== next_result.src_match) begin
            $error("src_match: expected %b, got %b", next_result.src_match, out_data.src_match);
            fail_count++;
          end
          if (out_data.tag_match !== next_result.tag_match) begin
            $error("tag_match: expected %b, got %b", next_result.tag_match, out_data.tag_match);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else if (!tail_quiet && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        out_gap <= $urandom_range(0, 15);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // register write: setup then access, the register takes the value at the ready edge
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr[4:3])
      REG_DST_MAC:  dst_mac_cfg = value[47:0];
      REG_SRC_MAC:  src_mac_cfg = value[47:0];
      REG_TAG_WORD: tag_word_cfg = value[31:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // register read, data sampled at the ready edge of the access phase
  task automatic cfg_read_check(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] want,
                                input string reg_name);
    logic [63:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $error("%s readback: expected %h, got %h", reg_name, want, got);
      fail_count++;
    end
  endtask

  // sender holds off until every frame summary is back, then lets the pipe settle
  task automatic wait_idle();
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || frame_results.size() != 0);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // new match settings between traffic phases, incl. a write to the unmapped slot
  task automatic apply_settings(input logic [63:0] dst, input logic [63:0] src,
                                input logic [63:0] tag);
    wait_idle();
    cfg_write({REG_DST_MAC, 3'b000}, dst);
    cfg_write({REG_SRC_MAC, 3'b000}, src);
    cfg_write({REG_TAG_WORD, 3'b000}, tag);
    cfg_write({REG_UNMAPPED, 3'b000}, {$urandom, $urandom});
    cfg_read_check({REG_DST_MAC, 3'b000}, {16'h0000, dst_mac_cfg}, "dst_mac");
    cfg_read_check({REG_SRC_MAC, 3'b000}, {16'h0000, src_mac_cfg}, "src_mac");
    cfg_read_check({REG_TAG_WORD, 3'b000}, {32'h0, tag_word_cfg}, "tag_word");
    @(negedge clk);
  endtask

  // queue one frame; fill < 0 means random bytes, the hit flags copy the
  // configured values into the address and tag fields
  task automatic push_frame(input int unsigned len, input logic [15:0] tpid, input bit hit_dst,
                            input bit hit_src, input bit hit_tag, input int fill);
    in_item_t item;
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i < 6 && hit_dst) b = dst_mac_cfg[8*(5-i) +: 8];
      else if (i >= 6 && i < 12 && hit_src) b = src_mac_cfg[8*(11-i) +: 8];
      else if (i >= 12 && i < 16 && hit_tag) b = tag_word_cfg[8*(15-i) +: 8];
      else if (i == 12) b = tpid[15:8];
      else if (i == 13) b = tpid[7:0];
      item.data_byte = b;
      item.last = (i == len - 1);
      byte_queue.push_back(item);
    end
  endtask

  // mostly well-formed headers with random contents, some runt frames among them
  task automatic queue_random_traffic(input int unsigned min_bytes,
                                      input int unsigned min_frames);
    int unsigned sent_bytes;
    int unsigned sent_frames;
    int unsigned len;
    int unsigned pick;
    logic [15:0] tpid;
    sent_bytes = 0;
    sent_frames = 0;
    while (sent_bytes < min_bytes || sent_frames < min_frames) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) len = $urandom_range(1, 13);
      else if (pick < 55) len = $urandom_range(14, 24);
      else if (pick < 97) len = $urandom_range(25, 64);
      else len = $urandom_range(65, 300);
      pick = $urandom_range(0, 9);
      if (pick < 3) tpid = TPID_VLAN;
      else if (pick < 6) tpid = TPID_QINQ_OLD;
      else tpid = 16'($urandom);
      push_frame(len, tpid, $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 2) == 0, -1);
      sent_bytes += len;
      sent_frames++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings (all zero): zero-filled frames around each length threshold
    push_frame(1, 16'h0000, 0, 0, 0, 0);
    push_frame(5, 16'h0000, 0, 0, 0, 0);
    push_frame(6, 16'h0000, 0, 0, 0, 0);
    push_frame(12, 16'h0000, 0, 0, 0, 0);
    push_frame(13, 16'h0000, 0, 0, 0, 0);
    push_frame(14, 16'h0000, 0, 0, 0, 0);
    push_frame(16, 16'h0000, 0, 0, 0, 0);
    // vlan: too short for the inner type, inner type but no strip, stripped
    push_frame(15, TPID_VLAN, 0, 0, 0, -1);
    push_frame(17, TPID_VLAN, 0, 0, 0, -1);
    push_frame(18, TPID_VLAN, 0, 0, 0, -1);
    push_frame(19, TPID_VLAN, 0, 0, 0, -1);
    // old qinq around its 22-byte threshold
    push_frame(21, TPID_QINQ_OLD, 0, 0, 0, -1);
    push_frame(22, TPID_QINQ_OLD, 0, 0, 0, -1);
    push_frame(23, TPID_QINQ_OLD, 0, 0, 0, -1);

    // all ones, upper write bits set to show they are dropped; all-ones frames
    apply_settings('1, '1, '1);
    push_frame(6, 16'hFFFF, 0, 0, 0, 8'hFF);
    push_frame(11, 16'hFFFF, 0, 0, 0, 8'hFF);
    push_frame(12, 16'hFFFF, 0, 0, 0, 8'hFF);
    push_frame(14, 16'hFFFF, 0, 0, 0, 8'hFF);
    push_frame(16, 16'hFFFF, 0, 0, 0, 8'hFF);
    queue_random_traffic(60, 2);

    // random addresses, tag word shaped like a vlan tag
    apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                   {32'h0, TPID_VLAN, 16'($urandom)});
    queue_random_traffic(100, 3);

    // back to zero; one long frame with both addresses matching
    apply_settings('0, '0, '0);
    queue_random_traffic(60, 2);
    push_frame(100, TPID_QINQ_OLD, 1, 1, 0, -1);
    queue_random_traffic(20, 1);

    // final stretch with no idling on either side
    apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                   {32'h0, TPID_QINQ_OLD, 16'($urandom)});
    tail_quiet = 1'b1;
    queue_random_traffic(100, 3);

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
